[hdl/gpioic_pkg.sv]
package gpioic_pkg;

	// Register window byte offsets
	localparam logic [7:0] OFF_DIR  = 8'h00;
	localparam logic [7:0] OFF_OUT  = 8'h04;
	localparam logic [7:0] OFF_IN   = 8'h08;
	localparam logic [7:0] OFF_IE   = 8'h0C;
	localparam logic [7:0] OFF_IS   = 8'h10;
	localparam logic [7:0] OFF_TRIG = 8'h14;
	localparam logic [7:0] OFF_POL  = 8'h18;

	// Access kind
	localparam logic REQ_READ  = 1'b0;
	localparam logic REQ_WRITE = 1'b1;

	localparam int DATA_W = 32;
	localparam int OFF_W  = 8;

	// One bus request
	typedef struct packed {
		logic              wr;
		logic [OFF_W-1:0]  offset;
		logic [DATA_W-1:0] data;
	} req_t;

	// One bus response
	typedef struct packed {
		logic [DATA_W-1:0] read_data;
		logic              irq;
		logic              bad;
	} rsp_t;

endpackage

[hdl/gpioic_regs.sv]
module gpioic_regs #(
	parameter int PIN_COUNT = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               upd,
	input  gpioic_pkg::req_t   req,
	output gpioic_pkg::rsp_t   rsp
);

	logic [PIN_COUNT-1:0] dir_q, out_q, ie_q, is_q, trig_q, pol_q;
	logic [PIN_COUNT-1:0] dir_n, out_n, ie_n, is_n, trig_n, pol_n;
	logic [PIN_COUNT-1:0] val, edge_hit, level, active, rd;
	logic                 bad;

	assign val = req.data[PIN_COUNT-1:0];

	// Edge detect on the output latch for edge-triggered enabled outputs
	assign edge_hit = (((~out_q & val) & pol_q) | ((out_q & ~val) & ~pol_q))
		& ~trig_q & dir_q & ie_q;

	// Pin level after the access, used by the level update
	assign level  = out_n & dir_n;
	assign active = ~(level ^ pol_n);

	// Decode the request and form next state and read data
	always_comb begin
		dir_n  = dir_q;
		out_n  = out_q;
		ie_n   = ie_q;
		is_n   = is_q;
		trig_n = trig_q;
		pol_n  = pol_q;
		rd     = '0;
		bad    = 1'b0;
		if (req.wr == gpioic_pkg::REQ_READ) begin
			case (req.offset)
				gpioic_pkg::OFF_DIR:  rd = dir_q;
				gpioic_pkg::OFF_OUT:  rd = out_q;
				gpioic_pkg::OFF_IN:   rd = out_q & dir_q;
				gpioic_pkg::OFF_IE:   rd = ie_q;
				gpioic_pkg::OFF_IS:   rd = is_q;
				gpioic_pkg::OFF_TRIG: rd = trig_q;
				gpioic_pkg::OFF_POL:  rd = pol_q;
				default:              bad = 1'b1;
			endcase
		end else begin
			case (req.offset)
				gpioic_pkg::OFF_DIR: begin
					dir_n = val;
					is_n  = (is_q & ~trig_q) | (active & trig_q);
				end
				gpioic_pkg::OFF_OUT: begin
					out_n = val;
					is_n  = ((is_q | edge_hit) & ~trig_q) | (active & trig_q);
				end
				gpioic_pkg::OFF_IE:   ie_n   = val;
				gpioic_pkg::OFF_IS:   is_n   = is_q & ~val;
				gpioic_pkg::OFF_TRIG: trig_n = val;
				gpioic_pkg::OFF_POL:  pol_n  = val;
				default:              bad    = 1'b1;
			endcase
		end
	end

	assign rsp.read_data = gpioic_pkg::DATA_W'(rd);
	assign rsp.irq       = |(is_n & ie_n);
	assign rsp.bad       = bad;

	// Commit the new register state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q  <= '0;
			out_q  <= '0;
			ie_q   <= '0;
			is_q   <= '0;
			trig_q <= '0;
			pol_q  <= '0;
		end else if (upd) begin
			dir_q  <= dir_n;
			out_q  <= out_n;
			ie_q   <= ie_n;
			is_q   <= is_n;
			trig_q <= trig_n;
			pol_q  <= pol_n;
		end
	end

	// A status write can only clear bits
	a_is_clear_only: assert property (@(posedge clk) disable iff (!arst_n)
		upd && req.wr == gpioic_pkg::REQ_WRITE && req.offset == gpioic_pkg::OFF_IS
		|=> (is_q & ~$past(is_q)) == '0)
		else $error("status write set a bit");

	// Enable, trigger and polarity writes leave status alone
	a_cfg_keeps_is: assert property (@(posedge clk) disable iff (!arst_n)
		upd && req.wr == gpioic_pkg::REQ_WRITE &&
		(req.offset == gpioic_pkg::OFF_IE || req.offset == gpioic_pkg::OFF_TRIG ||
		 req.offset == gpioic_pkg::OFF_POL)
		|=> $stable(is_q))
		else $error("config write changed status");

	// No state moves without an accepted request
	a_idle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!upd |=> $stable(is_q) && $stable(dir_q) && $stable(out_q))
		else $error("state changed while idle");

endmodule

[hdl/gpio_interrupt_controller_top.sv]
// GPIO controller with edge and level interrupts, driven by register requests.
// Slave stream: one request per transfer; tuser[0] is the access kind
// (0 read, 1 write), tdata carries the byte offset and the write data.
// Master stream: one response per request, in order; tdata is the read data
// (zero on writes and bad offsets), tuser holds the interrupt level after
// the access and the bad-access flag.
// Path: an accepted request is held in the input register, its response is formed
// from it by the register block and loaded into the result register, which drives
// the master stream. Throughput: one request per cycle while the receiver keeps
// tready high.
// Reset: all registers clear to zero (all pins inputs, edge triggered, low or
// falling polarity, no interrupts enabled or pending); both stages empty.
// Stall: when the receiver holds tready low the response stays in the result
// register; one more request is taken into the input register, after which
// tready drops until the response is taken.
module gpio_interrupt_controller_top #(
	parameter int PIN_COUNT = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // [7:0] reg_offset, [39:8] write_data
	input  logic [0:0]  s_axis_tuser,  // [0] req_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [31:0] read_data
	output logic [1:0]  m_axis_tuser   // [0] irq_line, [1] bad_access
);

	gpioic_pkg::req_t req_s1;
	gpioic_pkg::rsp_t rsp, rsp_s2;
	logic             valid_s1, valid_s2, advance;

	// Move stage 1 forward whenever the result register is free
	assign advance       = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			req_s1.wr     <= s_axis_tuser[0];
			req_s1.offset <= s_axis_tdata[7:0];
			req_s1.data   <= s_axis_tdata[39:8];
		end
	end

	gpioic_regs #(
		.PIN_COUNT(PIN_COUNT)
	) u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (valid_s1 && advance),
		.req    (req_s1),
		.rsp    (rsp)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			rsp_s2 <= rsp;
		end
	end

	assign m_axis_tvalid   = valid_s2;
	assign m_axis_tdata    = rsp_s2.read_data;
	assign m_axis_tuser[0] = rsp_s2.irq;
	assign m_axis_tuser[1] = rsp_s2.bad;

	// A flagged access never returns data
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && rsp_s2.bad |-> rsp_s2.read_data == '0)
		else $error("bad access returned data");

	// An empty result register never blocks the slave side
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> s_axis_tready)
		else $error("ready low with empty result register");

	// A request held in stage 1 during a stall is kept intact
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(req_s1))
		else $error("stalled request lost");

endmodule
